// ----- rtl/snpc_pkg.sv -----
package snpc_pkg;

    // kind of test carried by one transaction
    typedef enum logic {
        ACT_SPHERE = 1'b0,
        ACT_BOX    = 1'b1
    } action_t;

endpackage

// ----- rtl/snpc_delay.sv -----
module snpc_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic [WIDTH-1:0] d,
    output logic [WIDTH-1:0] q
);

    logic [WIDTH-1:0] line_reg [DEPTH];

    // side data shift line, moves with the pipeline enable
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                line_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            line_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++)
            begin
                line_reg[i] <= line_reg[i-1];
            end
        end
    end

    assign q = line_reg[DEPTH-1];

endmodule

// ----- rtl/snpc_sqrt.sv -----
module snpc_sqrt #(
    parameter int MW = 33
) (
    input  logic            clk,
    input  logic            en,
    input  logic [2*MW-1:0] radicand,
    output logic [MW-1:0]   root
);

    logic [MW+1:0]   rem_reg  [MW];
    logic [MW-1:0]   root_reg [MW];
    logic [2*MW-1:0] sh_reg   [MW];

    logic [MW+1:0]   rem_in   [MW];
    logic [MW-1:0]   root_in  [MW];
    logic [2*MW-1:0] sh_in    [MW];
    logic [MW+1:0]   rem_next  [MW];
    logic [MW-1:0]   root_next [MW];
    logic [2*MW-1:0] sh_next   [MW];

    // stage inputs: first stage from the port, others from the stage before
    always_comb
    begin
        rem_in[0]  = '0;
        root_in[0] = '0;
        sh_in[0]   = radicand;
        for (int k = 1; k < MW; k++)
        begin
            rem_in[k]  = rem_reg[k-1];
            root_in[k] = root_reg[k-1];
            sh_in[k]   = sh_reg[k-1];
        end
    end

    // one root bit per stage, two radicand bits brought down each time
    always_comb
    begin
        logic [MW+1:0] acc;
        logic [MW+1:0] trial;
        for (int k = 0; k < MW; k++)
        begin
            acc   = {rem_in[k][MW-1:0], sh_in[k][2*MW-1 -: 2]};
            trial = {root_in[k], 2'b01};
            if (acc >= trial)
            begin
                rem_next[k]  = acc - trial;
                root_next[k] = {root_in[k][MW-2:0], 1'b1};
            end
            else
            begin
                rem_next[k]  = acc;
                root_next[k] = {root_in[k][MW-2:0], 1'b0};
            end
            sh_next[k] = {sh_in[k][2*MW-3:0], 2'b00};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < MW; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                sh_reg[k]   <= sh_next[k];
            end
        end
    end

    assign root = root_reg[MW-1];

endmodule

// ----- rtl/snpc_div.sv -----
module snpc_div #(
    parameter int MW = 33,
    parameter int QW = 17
) (
    input  logic          clk,
    input  logic          en,
    input  logic [MW-1:0] dividend,
    input  logic [MW-1:0] divisor,
    output logic [QW-1:0] quotient
);

    logic [MW-1:0] rem_reg [QW];
    logic [MW-1:0] den_reg [QW];
    logic [QW-1:0] quo_reg [QW];

    logic [MW-1:0] rem_in [QW];
    logic [MW-1:0] den_in [QW];
    logic [QW-1:0] quo_in [QW];
    logic [MW-1:0] rem_next [QW];
    logic [QW-1:0] quo_next [QW];

    always_comb
    begin
        rem_in[0] = dividend;
        den_in[0] = divisor;
        quo_in[0] = '0;
        for (int k = 1; k < QW; k++)
        begin
            rem_in[k] = rem_reg[k-1];
            den_in[k] = den_reg[k-1];
            quo_in[k] = quo_reg[k-1];
        end
    end

    // restoring division, one quotient bit per stage; the integer bit comes first
    always_comb
    begin
        logic [MW:0] acc;
        logic        ge;
        for (int k = 0; k < QW; k++)
        begin
            if (k == 0)
            begin
                acc = {1'b0, rem_in[k]};
            end
            else
            begin
                acc = {rem_in[k], 1'b0};
            end
            ge = (acc >= {1'b0, den_in[k]});
            if (ge)
            begin
                acc = acc - {1'b0, den_in[k]};
            end
            rem_next[k] = acc[MW-1:0];
            quo_next[k] = {quo_in[k][QW-2:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < QW; k++)
            begin
                rem_reg[k] <= rem_next[k];
                den_reg[k] <= den_in[k];
                quo_reg[k] <= quo_next[k];
            end
        end
    end

    assign quotient = quo_reg[QW-1];

endmodule

// ----- rtl/sphere_narrow_phase_collision.sv -----
// Sphere narrow-phase collision test, signed fixed point with FRAC_BITS fraction bits.
// Input channel (in_valid/in_ready) takes one test per transaction: action selects
// sphere against sphere or sphere against an axis-aligned box given by world corners.
// Output channel (out_valid/out_ready) gives exactly one result per test, in order:
// hit flag, unit normal, contact point and penetration depth, all zero on a miss.
// Stages: three set-up stages, COORD_WIDTH+1 stages of the bit-per-stage square root,
// FRAC_BITS+1 stages of the normal dividers, a multiply stage and the output register.
// Throughput is one test per cycle unless a result waits on a stalled receiver; every
// stage is a register and all stages move on a single pipeline enable.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// in_ready drops in the same cycle; nothing is dropped or repeated.
// Reset clears every valid bit, so the block comes out of reset empty and ready.
module sphere_narrow_phase_collision #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          action,
    input  logic signed [COORD_WIDTH-1:0] sphere_x,
    input  logic signed [COORD_WIDTH-1:0] sphere_y,
    input  logic signed [COORD_WIDTH-1:0] sphere_z,
    input  logic        [COORD_WIDTH-2:0] sphere_radius,
    input  logic signed [COORD_WIDTH-1:0] other_x,
    input  logic signed [COORD_WIDTH-1:0] other_y,
    input  logic signed [COORD_WIDTH-1:0] other_z,
    input  logic signed [COORD_WIDTH-1:0] box_high_x,
    input  logic signed [COORD_WIDTH-1:0] box_high_y,
    input  logic signed [COORD_WIDTH-1:0] box_high_z,
    input  logic        [COORD_WIDTH-2:0] other_radius,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          hit,
    output logic signed [FRAC_BITS+1:0]   normal_x,
    output logic signed [FRAC_BITS+1:0]   normal_y,
    output logic signed [FRAC_BITS+1:0]   normal_z,
    output logic signed [COORD_WIDTH-1:0] contact_x,
    output logic signed [COORD_WIDTH-1:0] contact_y,
    output logic signed [COORD_WIDTH-1:0] contact_z,
    output logic        [COORD_WIDTH-2:0] depth
);

    localparam int CW = COORD_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int DW = CW + 1;
    localparam int AW = CW + 1;
    localparam int SW = 2 * CW + 2;
    localparam int MW = CW + 1;
    localparam int RW = CW - 1;
    localparam int NW = F + 2;
    localparam int QW = F + 1;
    localparam int PW = QW + RW;
    localparam int WA = 2 + 3 * AW + 3 + 3 * CW + CW + RW;
    localparam int WB = 3 + 3 + 3 * CW + RW + RW;
    localparam logic signed [NW-1:0] NORM_ONE = {2'b01, {F{1'b0}}};
    localparam logic signed [CW+1:0] C_MAX = {3'b000, {(CW-1){1'b1}}};
    localparam logic signed [CW+1:0] C_MIN = {3'b111, {(CW-1){1'b0}}};

    logic en;

    // the pipeline moves whenever the output register is free or being emptied
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    // ---------------- stage 1: difference vector, clamp and radius sums
    logic signed [CW-1:0] s_in [3];
    logic signed [CW-1:0] o_in [3];
    logic signed [CW-1:0] h_in [3];
    logic                 is_box;

    assign s_in[0] = sphere_x;
    assign s_in[1] = sphere_y;
    assign s_in[2] = sphere_z;
    assign o_in[0] = other_x;
    assign o_in[1] = other_y;
    assign o_in[2] = other_z;
    assign h_in[0] = box_high_x;
    assign h_in[1] = box_high_y;
    assign h_in[2] = box_high_z;
    assign is_box  = (snpc_pkg::action_t'(action) == snpc_pkg::ACT_BOX);

    logic [AW-1:0]        p1_absd_next [3];
    logic                 p1_dneg_next [3];
    logic signed [CW-1:0] p1_base_next [3];
    logic [CW-1:0]        p1_rref_next;

    always_comb
    begin
        logic signed [CW-1:0] clo;
        logic signed [CW-1:0] bpt;
        logic signed [DW-1:0] dd;
        for (int i = 0; i < 3; i++)
        begin
            // upper bound first, so an inverted box lands on the low corner
            clo = (s_in[i] < h_in[i]) ? s_in[i] : h_in[i];
            bpt = (clo < o_in[i]) ? o_in[i] : clo;
            if (is_box)
            begin
                dd = {bpt[CW-1], bpt} - {s_in[i][CW-1], s_in[i]};
                p1_base_next[i] = bpt;
            end
            else
            begin
                dd = {o_in[i][CW-1], o_in[i]} - {s_in[i][CW-1], s_in[i]};
                p1_base_next[i] = s_in[i];
            end
            p1_dneg_next[i] = dd[DW-1];
            p1_absd_next[i] = dd[DW-1] ? AW'(-dd) : AW'(dd);
        end
        if (is_box)
        begin
            p1_rref_next = {1'b0, sphere_radius};
        end
        else
        begin
            p1_rref_next = {1'b0, sphere_radius} + {1'b0, other_radius};
        end
    end

    logic                 p1_valid_reg;
    logic                 p1_box_reg;
    logic [AW-1:0]        p1_absd_reg [3];
    logic                 p1_dneg_reg [3];
    logic signed [CW-1:0] p1_base_reg [3];
    logic [CW-1:0]        p1_rref_reg;
    logic [RW-1:0]        p1_rcon_reg;

    // ---------------- stage 2: squares
    logic                 p2_valid_reg;
    logic                 p2_box_reg;
    logic [SW-1:0]        p2_sq_reg [3];
    logic [2*CW-1:0]      p2_lim_reg;
    logic [AW-1:0]        p2_absd_reg [3];
    logic                 p2_dneg_reg [3];
    logic signed [CW-1:0] p2_base_reg [3];
    logic [CW-1:0]        p2_rref_reg;
    logic [RW-1:0]        p2_rcon_reg;

    // ---------------- stage 3: squared length and hit decision
    logic [SW-1:0]        p3_sum_next;
    logic                 p3_hit_next;
    logic                 p3_valid_reg;
    logic                 p3_hit_reg;
    logic [SW-1:0]        p3_sum_reg;
    logic [AW-1:0]        p3_absd_reg [3];
    logic                 p3_dneg_reg [3];
    logic signed [CW-1:0] p3_base_reg [3];
    logic [CW-1:0]        p3_rref_reg;
    logic [RW-1:0]        p3_rcon_reg;

    assign p3_sum_next = p2_sq_reg[0] + p2_sq_reg[1] + p2_sq_reg[2];
    assign p3_hit_next = p2_box_reg ? (p3_sum_next <= {2'b00, p2_lim_reg})
                                    : (p3_sum_next <  {2'b00, p2_lim_reg});

    // valid bits of the set-up stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p1_valid_reg <= in_valid;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
        end
    end

    // payload of the set-up stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_box_reg  <= is_box;
            p1_rref_reg <= p1_rref_next;
            p1_rcon_reg <= sphere_radius;
            p2_box_reg  <= p1_box_reg;
            p2_lim_reg  <= p1_rref_reg * p1_rref_reg;
            p2_rref_reg <= p1_rref_reg;
            p2_rcon_reg <= p1_rcon_reg;
            p3_hit_reg  <= p3_hit_next;
            p3_sum_reg  <= p3_sum_next;
            p3_rref_reg <= p2_rref_reg;
            p3_rcon_reg <= p2_rcon_reg;
            for (int i = 0; i < 3; i++)
            begin
                p1_absd_reg[i] <= p1_absd_next[i];
                p1_dneg_reg[i] <= p1_dneg_next[i];
                p1_base_reg[i] <= p1_base_next[i];
                p2_sq_reg[i]   <= p1_absd_reg[i] * p1_absd_reg[i];
                p2_absd_reg[i] <= p1_absd_reg[i];
                p2_dneg_reg[i] <= p1_dneg_reg[i];
                p2_base_reg[i] <= p1_base_reg[i];
                p3_absd_reg[i] <= p2_absd_reg[i];
                p3_dneg_reg[i] <= p2_dneg_reg[i];
                p3_base_reg[i] <= p2_base_reg[i];
            end
        end
    end

    // ---------------- square root of the squared length
    logic [MW-1:0] root;

    snpc_sqrt #(
        .MW(MW)
    ) u_sqrt (
        .clk      (clk),
        .en       (en),
        .radicand (p3_sum_reg),
        .root     (root)
    );

    logic [WA-1:0]        side_a_in;
    logic [WA-1:0]        side_a_out;
    logic                 a_valid;
    logic                 a_hit;
    logic [AW-1:0]        a_absd [3];
    logic                 a_dneg [3];
    logic signed [CW-1:0] a_base [3];
    logic [CW-1:0]        a_rref;
    logic [RW-1:0]        a_rcon;

    assign side_a_in = {p3_valid_reg, p3_hit_reg,
                        p3_absd_reg[0], p3_absd_reg[1], p3_absd_reg[2],
                        p3_dneg_reg[0], p3_dneg_reg[1], p3_dneg_reg[2],
                        p3_base_reg[0], p3_base_reg[1], p3_base_reg[2],
                        p3_rref_reg, p3_rcon_reg};

    snpc_delay #(
        .WIDTH(WA),
        .DEPTH(MW)
    ) u_side_a (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .d     (side_a_in),
        .q     (side_a_out)
    );

    assign {a_valid, a_hit, a_absd[0], a_absd[1], a_absd[2],
            a_dneg[0], a_dneg[1], a_dneg[2],
            a_base[0], a_base[1], a_base[2], a_rref, a_rcon} = side_a_out;

    // penetration depth from the root, saturated to the field range
    logic [MW-1:0] dep_diff;
    logic [RW-1:0] a_depth;

    assign dep_diff = (root > {1'b0, a_rref}) ? (root - {1'b0, a_rref})
                                              : ({1'b0, a_rref} - root);
    assign a_depth  = (dep_diff[MW-1:RW] != '0) ? {RW{1'b1}} : dep_diff[RW-1:0];

    // ---------------- normal components, one divider lane per axis
    logic [QW-1:0] quo [3];

    for (genvar g = 0; g < 3; g++)
    begin : g_lane
        snpc_div #(
            .MW(MW),
            .QW(QW)
        ) u_div (
            .clk      (clk),
            .en       (en),
            .dividend (a_absd[g]),
            .divisor  (root),
            .quotient (quo[g])
        );
    end

    logic [WB-1:0]        side_b_in;
    logic [WB-1:0]        side_b_out;
    logic                 b_valid;
    logic                 b_hit;
    logic                 b_mzero;
    logic                 b_dneg [3];
    logic signed [CW-1:0] b_base [3];
    logic [RW-1:0]        b_rcon;
    logic [RW-1:0]        b_depth;

    assign side_b_in = {a_valid, a_hit, (root == '0),
                        a_dneg[0], a_dneg[1], a_dneg[2],
                        a_base[0], a_base[1], a_base[2], a_rcon, a_depth};

    snpc_delay #(
        .WIDTH(WB),
        .DEPTH(QW)
    ) u_side_b (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .d     (side_b_in),
        .q     (side_b_out)
    );

    assign {b_valid, b_hit, b_mzero, b_dneg[0], b_dneg[1], b_dneg[2],
            b_base[0], b_base[1], b_base[2], b_rcon, b_depth} = side_b_out;

    // ---------------- multiply stage: normal magnitude times radius
    logic [QW-1:0]        pm_nmag_next [3];
    logic                 pm_valid_reg;
    logic                 pm_hit_reg;
    logic [QW-1:0]        pm_nmag_reg [3];
    logic                 pm_dneg_reg [3];
    logic [PW-1:0]        pm_prod_reg [3];
    logic signed [CW-1:0] pm_base_reg [3];
    logic [RW-1:0]        pm_depth_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (b_mzero)
            begin
                pm_nmag_next[i] = '0;
            end
            else if (quo[i] > NORM_ONE[QW-1:0])
            begin
                pm_nmag_next[i] = NORM_ONE[QW-1:0];
            end
            else
            begin
                pm_nmag_next[i] = quo[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pm_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            pm_valid_reg <= b_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pm_hit_reg   <= b_hit;
            pm_depth_reg <= b_depth;
            for (int i = 0; i < 3; i++)
            begin
                pm_nmag_reg[i] <= pm_nmag_next[i];
                pm_dneg_reg[i] <= b_dneg[i];
                pm_prod_reg[i] <= pm_nmag_next[i] * b_rcon;
                pm_base_reg[i] <= b_base[i];
            end
        end
    end

    // ---------------- output stage: contact point, signed normal, miss gating
    logic signed [NW-1:0] norm_next [3];
    logic signed [CW-1:0] cont_next [3];

    always_comb
    begin
        logic [CW-1:0]        off;
        logic signed [CW+1:0] csum;
        logic signed [NW-1:0] nabs;
        for (int i = 0; i < 3; i++)
        begin
            off  = pm_prod_reg[i][PW-1:F];
            nabs = $signed({1'b0, pm_nmag_reg[i]});
            if (pm_dneg_reg[i])
            begin
                csum = {{2{pm_base_reg[i][CW-1]}}, pm_base_reg[i]} - $signed({2'b00, off});
                norm_next[i] = -nabs;
            end
            else
            begin
                csum = {{2{pm_base_reg[i][CW-1]}}, pm_base_reg[i]} + $signed({2'b00, off});
                norm_next[i] = nabs;
            end
            if (csum > C_MAX)
            begin
                cont_next[i] = C_MAX[CW-1:0];
            end
            else if (csum < C_MIN)
            begin
                cont_next[i] = C_MIN[CW-1:0];
            end
            else
            begin
                cont_next[i] = csum[CW-1:0];
            end
            if (!pm_hit_reg)
            begin
                norm_next[i] = '0;
                cont_next[i] = '0;
            end
        end
    end

    logic                 out_valid_reg;
    logic                 out_hit_reg;
    logic signed [NW-1:0] out_norm_reg [3];
    logic signed [CW-1:0] out_cont_reg [3];
    logic [RW-1:0]        out_depth_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= pm_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_hit_reg   <= pm_hit_reg;
            out_depth_reg <= pm_hit_reg ? pm_depth_reg : '0;
            for (int i = 0; i < 3; i++)
            begin
                out_norm_reg[i] <= norm_next[i];
                out_cont_reg[i] <= cont_next[i];
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = out_hit_reg;
    assign normal_x  = out_norm_reg[0];
    assign normal_y  = out_norm_reg[1];
    assign normal_z  = out_norm_reg[2];
    assign contact_x = out_cont_reg[0];
    assign contact_y = out_cont_reg[1];
    assign contact_z = out_cont_reg[2];
    assign depth     = out_depth_reg;

`ifndef NO_ASSERTIONS
    // an accepted transaction always enters the first stage
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> p1_valid_reg)
        else $error("accepted transaction lost at pipeline entry");

    // input is refused only while a result waits on a stalled receiver
    a_refuse_only_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input refused without output stall");

    // a miss carries an all-zero result; checked on the normal, contact_x and depth
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> normal_x == '0 && normal_y == '0 && normal_z == '0
                              && contact_x == '0 && depth == '0)
        else $error("miss result not cleared");

    // the x and y normal components never exceed unit length
    a_normal_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> normal_x <= NORM_ONE && normal_x >= -NORM_ONE
                      && normal_y <= NORM_ONE && normal_y >= -NORM_ONE)
        else $error("normal component out of range");
`endif

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

// collision test bench: drives sphere/sphere and sphere/box tests, predicts results
module testbench;

    localparam int CW  = 32;
    localparam int FB  = 16;
    localparam int NUM_RANDOM = 2000;

    typedef struct packed {
        logic                 hit;
        logic signed [FB+1:0] nx, ny, nz;
        logic signed [CW-1:0] cx, cy, cz;
        logic        [CW-2:0] dep;
    } collision_t;

    typedef struct {
        snpc_pkg::action_t    act;
        logic signed [CW-1:0] sx, sy, sz;
        logic        [CW-2:0] sr;
        logic signed [CW-1:0] ox, oy, oz;
        logic signed [CW-1:0] hx, hy, hz;
        logic        [CW-2:0] orad;
    } pair_test_t;

    // integer square root, floor, of a 100-bit value
    function automatic logic [63:0] isqrt(logic [99:0] s);
        logic [63:0] m;
        logic [63:0] cand;
        m = 0;
        for (int b = 62; b >= 0; b--) begin
            cand = m | (64'd1 << b);
            if ({64'd0, cand} * {64'd0, cand} <= {28'd0, s})
                m = cand;
        end
        return m;
    endfunction

    // one normal component: |d| scaled by 2^FB over m, capped at unity
    function automatic logic signed [63:0] unit_part(logic signed [63:0] d, logic [63:0] m);
        logic [63:0] a;
        logic [127:0] q;
        a = d < 0 ? -d : d;
        q = ({64'd0, a} << FB) / {64'd0, m};
        if (q > (128'd1 << FB))
            q = 128'd1 << FB;
        return d < 0 ? -$signed(q[63:0]) : $signed(q[63:0]);
    endfunction

    // contact coordinate, saturated to the coordinate range
    function automatic logic signed [CW-1:0] touch_point(logic signed [63:0] b,
            logic signed [63:0] n, logic [63:0] r);
        logic [127:0] p;
        logic signed [63:0] c;
        p = {64'd0, (n < 0 ? -n : n)} * {64'd0, r};
        p = p >> FB;
        c = n < 0 ? b - $signed(p[63:0]) : b + $signed(p[63:0]);
        if (c > 64'sd2147483647) c = 64'sd2147483647;
        if (c < -64'sd2147483648) c = -64'sd2147483648;
        return c[CW-1:0];
    endfunction

    function automatic collision_t collide(pair_test_t t);
        collision_t r;
        logic signed [63:0] s[3], o[3], h[3], d[3], b[3], c, n;
        logic [63:0] rref, m, dep;
        logic [99:0] sq, lim, a;
        logic hitv;
        s = '{t.sx, t.sy, t.sz};
        o = '{t.ox, t.oy, t.oz};
        h = '{t.hx, t.hy, t.hz};
        r = '{default: '0};
        for (int i = 0; i < 3; i++) begin
            if (t.act == snpc_pkg::ACT_SPHERE) begin
                d[i] = o[i] - s[i];
                b[i] = s[i];
            end else begin
                c = s[i] < h[i] ? s[i] : h[i];
                if (c < o[i]) c = o[i];
                b[i] = c;
                d[i] = c - s[i];
            end
        end
        rref = t.act == snpc_pkg::ACT_SPHERE ? 64'(t.sr) + 64'(t.orad) : 64'(t.sr);
        sq = 0;
        for (int i = 0; i < 3; i++) begin
            a = d[i] < 0 ? 100'(-d[i]) : 100'(d[i]);
            sq = sq + a * a;
        end
        lim = 100'(rref) * 100'(rref);
        hitv = t.act == snpc_pkg::ACT_SPHERE ? sq < lim : sq <= lim;
        if (!hitv)
            return r;
        m = isqrt(sq);
        r.hit = 1'b1;
        for (int i = 0; i < 3; i++) begin
            n = m == 0 ? 64'sd0 : unit_part(d[i], m);
            case (i)
                0: begin r.nx = n[FB+1:0]; r.cx = touch_point(b[i], n, 64'(t.sr)); end
                1: begin r.ny = n[FB+1:0]; r.cy = touch_point(b[i], n, 64'(t.sr)); end
                default: begin r.nz = n[FB+1:0]; r.cz = touch_point(b[i], n, 64'(t.sr)); end
            endcase
        end
        dep = m > rref ? m - rref : rref - m;
        if (dep > 64'h7FFF_FFFF) dep = 64'h7FFF_FFFF;
        r.dep = dep[CW-2:0];
        return r;
    endfunction

    // in-order store of predicted results
    class collision_board;
        collision_t pending[$];
        int errors = 0;

        function void note(pair_test_t t);
            pending.push_back(collide(t));
        endfunction

        function void check(collision_t got);
            collision_t w;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result, hit=%0d", got.hit);
                return;
            end
            w = pending.pop_front();
            if (w !== got) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch: exp hit%0d n(%0d %0d %0d) c(%0d %0d %0d) d%0d",
                        w.hit, w.nx, w.ny, w.nz, w.cx, w.cy, w.cz, w.dep);
                    $display("          got hit%0d n(%0d %0d %0d) c(%0d %0d %0d) d%0d",
                        got.hit, got.nx, got.ny, got.nz, got.cx, got.cy, got.cz, got.dep);
                end
            end
        endfunction
    endclass

    logic clk = 0, rst_n = 0;
    logic in_valid = 0, in_ready, out_valid, out_ready = 0;
    logic action = 0;
    logic signed [CW-1:0] sphere_x = 0, sphere_y = 0, sphere_z = 0;
    logic        [CW-2:0] sphere_radius = 0, other_radius = 0;
    logic signed [CW-1:0] other_x = 0, other_y = 0, other_z = 0;
    logic signed [CW-1:0] box_high_x = 0, box_high_y = 0, box_high_z = 0;
    logic hit;
    logic signed [FB+1:0] normal_x, normal_y, normal_z;
    logic signed [CW-1:0] contact_x, contact_y, contact_z;
    logic        [CW-2:0] depth;

    collision_board board = new();
    bit stim_done = 0;
    bit hold_off = 0;

    sphere_narrow_phase_collision dut (.*);

    // clock
    always begin
        #4 clk = 1;
        #4 clk = 0;
    end

    // random coordinate, biased to small and extreme values
    function automatic logic signed [CW-1:0] coord();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
        endcase
    endfunction

    function automatic logic [CW-2:0] rad();
        case ($urandom_range(0, 4))
            0: return $urandom();
            1: return 31'h7FFF_FFFF;
            default: return $urandom_range(0, 32'h0003_0000);
        endcase
    endfunction

    function automatic pair_test_t random_test();
        pair_test_t t;
        t.act = snpc_pkg::action_t'($urandom_range(0, 1));
        t.sx = coord(); t.sy = coord(); t.sz = coord();
        t.sr = rad(); t.orad = rad();
        t.ox = coord(); t.oy = coord(); t.oz = coord();
        t.hx = coord(); t.hy = coord(); t.hz = coord();
        // mostly well-formed boxes, high corner a short way above the low corner
        if (t.act == snpc_pkg::ACT_BOX && $urandom_range(0, 3) != 0) begin
            t.hx = t.ox + $urandom_range(0, 32'h0002_0000);
            t.hy = t.oy + $urandom_range(0, 32'h0002_0000);
            t.hz = t.oz + $urandom_range(0, 32'h0002_0000);
        end
        return t;
    endfunction

    // offer one transaction and wait for acceptance
    task automatic send(pair_test_t t);
        in_valid      <= 1'b1;
        action        <= t.act;
        sphere_x      <= t.sx; sphere_y <= t.sy; sphere_z <= t.sz;
        sphere_radius <= t.sr; other_radius <= t.orad;
        other_x       <= t.ox; other_y <= t.oy; other_z <= t.oz;
        box_high_x    <= t.hx; box_high_y <= t.hy; box_high_z <= t.hz;
        do @(posedge clk); while (!in_ready);
        board.note(t);
    endtask

    task automatic send_gap(pair_test_t t, bit gaps);
        int g;
        g = gaps ? $urandom_range(0, 12) : 0;
        if (g > 0) begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        send(t);
    endtask

    function automatic pair_test_t mk(snpc_pkg::action_t a, int sx, int sy, int sz, int sr,
            int ox, int oy, int oz, int hx, int hy, int hz, int orad);
        pair_test_t t;
        t = '{a, sx, sy, sz, sr[30:0], ox, oy, oz, hx, hy, hz, orad[30:0]};
        return t;
    endfunction

    // stimulus
    initial begin
        pair_test_t t;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed cases
        send(mk(snpc_pkg::ACT_SPHERE, 0, 0, 0, 'h10000, 'h8000, 0, 0, 0, 0, 0, 'h10000));
        send(mk(snpc_pkg::ACT_SPHERE, 0, 0, 0, 'h10000, 'h20000, 0, 0, 0, 0, 0, 'h10000));
        send(mk(snpc_pkg::ACT_SPHERE, 5, 5, 5, 'h100, 5, 5, 5, -1, -1, -1, 'h100));
        send(mk(snpc_pkg::ACT_SPHERE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send(mk(snpc_pkg::ACT_SPHERE, 'h7FFFFFFF, 'h7FFFFFFF, 'h7FFFFFFF, 'h7FFFFFFF,
            'h80000000, 'h80000000, 'h80000000, 0, 0, 0, 'h7FFFFFFF));
        send(mk(snpc_pkg::ACT_SPHERE, 'h80000000, 0, 'h7FFFFFFF, 'h7FFFFFFF,
            'h7FFFFFFF, 'h7FFFFFFF, 'h80000000, 'h7FFFFFFF, 'h80000000, 5, 'h7FFFFFFF));
        send(mk(snpc_pkg::ACT_BOX, 0, 0, 0, 'h10000, 'h8000, -'h10000, -'h10000,
            'h20000, 'h10000, 'h10000, 'h7FFFFFFF));
        send(mk(snpc_pkg::ACT_BOX, 0, 0, 0, 'h10000, -'h10000, -'h10000, -'h10000,
            'h10000, 'h10000, 'h10000, 0));
        send(mk(snpc_pkg::ACT_BOX, 0, 0, 0, 'h10000, 'h10000, 0, 0, 'h20000, 0, 0, 0));
        send(mk(snpc_pkg::ACT_BOX, 0, 0, 0, 'h10000, 'h20000, 0, 0, -'h20000, 0, 0, 0));
        send(mk(snpc_pkg::ACT_BOX, 'h7FFFFFFF, 'h80000000, 0, 'h7FFFFFFF, 'h80000000,
            'h80000000, 'h80000000, 'h7FFFFFFF, 'h7FFFFFFF, 'h7FFFFFFF, 'h7FFFFFFF));
        send(mk(snpc_pkg::ACT_BOX, 'h80000000, 'h80000000, 'h80000000, 'h7FFFFFFF,
            'h7FFFFFFF, 'h7FFFFFFF, 'h7FFFFFFF, 'h80000000, 'h80000000, 'h80000000, 0));
        // receiver holds off while the sender keeps offering
        hold_off = 1'b1;
        repeat (150) begin
            t = random_test();
            send(t);
        end
        hold_off = 1'b0;
        // sender pauses until every result has come
        in_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
        for (int i = 0; i < NUM_RANDOM; i++) begin
            t = random_test();
            send_gap(t, (i / 200) % 2 == 0);
        end
        in_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // receiver stall pattern; a long hold-off counted here
    initial begin
        int g;
        @(posedge rst_n);
        while (!hold_off) @(posedge clk);
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        forever begin
            g = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            if (g > 0) begin
                out_ready <= 1'b0;
                repeat (g) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!(out_valid && out_ready)) @(posedge clk);
        end
    end

    // result monitor
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            board.check('{hit, normal_x, normal_y, normal_z,
                contact_x, contact_y, contact_z, depth});
    end

    // end of run
    initial begin
        wait (stim_done);
        while (board.pending.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    // watchdog
    initial begin
        #4000000;
        $display("testbench: done, errors");
        $finish;
    end

endmodule

// ----- sphere_narrow_phase_collision.f -----
rtl/snpc_pkg.sv
rtl/snpc_delay.sv
rtl/snpc_sqrt.sv
rtl/snpc_div.sv
rtl/sphere_narrow_phase_collision.sv
dv/testbench.sv
